FILE: src/tmc_pkg.sv
// ----------------------------------------------------------------------------
// tmc_pkg
// Shared constants and types of the tile map rectangle collision core.
// ----------------------------------------------------------------------------
`default_nettype none

package tmc_pkg;

	// Tile store geometry.
	localparam int MAX_COLS  = 64;
	localparam int MAX_ROWS  = 64;
	localparam int TILE_BITS = 8;
	localparam int DEPTH     = MAX_COLS * MAX_ROWS;
	localparam int ADDR_W    = $clog2(DEPTH);
	localparam int COL_W     = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int ROW_W     = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

	// Floor division: 16-bit magnitude dividend, 8-bit divisor, one bit a cycle.
	localparam int QW        = 16;
	localparam int DW        = 8;
	localparam int DIV_STEPS = QW;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	// Request kinds.
	localparam logic REQ_WRITE = 1'b0;
	localparam logic REQ_QUERY = 1'b1;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_TILE_SIZE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_COLS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAP_ROWS  = 2'd2;

	// Controls shared by the four dividers.
	typedef struct packed {
		logic load;
		logic step;
	} div_ctrl_t;

endpackage

`default_nettype wire

FILE: src/tilemap_rect_collision_core.sv
// ----------------------------------------------------------------------------
// tilemap_rect_collision_core
// Tile map store with rectangle collision query.
// ----------------------------------------------------------------------------
// After reset the core clears its 4096-entry tile store, one entry a cycle,
// and holds busy high until that pass is done. A tile write is taken while
// idle and its result (no hit) appears on the next cycle; busy stays low, so
// writes may follow back to back. A query keeps busy high while it works:
// it loads the dividers, runs the four floor divisions (one quotient bit a
// cycle), clamps the span, then issues one tile-store read per covered tile,
// stopping at the first nonzero tile. A query whose span is empty reports
// without reading any tile. Each result is shown for a single cycle with
// done high and must be taken then, since the receiver cannot hold it off.
// The user must write configuration only while the core is idle; the core
// itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module tilemap_rect_collision_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic                            req_type,
	input  wire logic [5:0]                      tile_col,
	input  wire logic [5:0]                      tile_row,
	input  wire logic [7:0]                      tile_value,
	input  wire logic signed [15:0]              rect_x,
	input  wire logic signed [15:0]              rect_y,
	input  wire logic [14:0]                     rect_w,
	input  wire logic [14:0]                     rect_h,
	input  wire logic                            cfg_we,
	input  wire logic [tmc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [7:0]                      cfg_data,
	output logic                                 done,
	output logic                                 hit,
	output logic [7:0]                           first_tile
);

	localparam logic [2:0] ST_CLEAR = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_PREP  = 3'd2;
	localparam logic [2:0] ST_DIV   = 3'd3;
	localparam logic [2:0] ST_SPAN  = 3'd4;
	localparam logic [2:0] ST_SCAN  = 3'd5;

	localparam int QW  = tmc_pkg::QW;
	localparam int AW  = tmc_pkg::ADDR_W;
	localparam int CW  = tmc_pkg::COL_W;
	localparam int RW  = tmc_pkg::ROW_W;
	localparam int TB  = tmc_pkg::TILE_BITS;

	// Configuration registers.
	logic [7:0] tile_size_q;
	logic [6:0] map_cols_q;
	logic [6:0] map_rows_q;

	logic [2:0]              state_q;
	logic [AW-1:0]           clr_addr_q;
	logic [tmc_pkg::CNT_W-1:0] cnt_q;

	// Span numerators, captured with the request.
	logic signed [QW:0] left_n_q, right_n_q, top_n_q, bottom_n_q;

	// Scan state.
	logic [CW-1:0] col_q, hi_col_q;
	logic [RW-1:0] row_q, lo_row_q, hi_row_q;
	logic          issue_q;
	logic          vld_s1;
	logic          last_s1;

	logic       done_q;
	logic       hit_q;
	logic [7:0] first_q;

	tmc_pkg::div_ctrl_t div_ctrl;
	logic [7:0]         ts_eff;
	logic [QW-1:0]      q_left, q_right, q_top, q_bottom;
	logic               n_left, n_right, n_top, n_bottom;

	logic          accept;
	logic          wr_tile;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [TB-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [TB-1:0] ram_rdata;

	logic [QW-1:0] lim_c, lim_r, lo_c, lo_r, hi_c, hi_r;
	logic          empty_c, empty_r;
	logic          last_issue;

	function automatic logic [AW-1:0] tile_addr(input logic [CW-1:0] c,
		input logic [RW-1:0] r);
		tile_addr = AW'(r) * AW'(tmc_pkg::MAX_COLS) + AW'(c);
	endfunction

	function automatic logic [QW-1:0] clamp_hi(input logic [QW-1:0] q,
		input logic [QW-1:0] lim);
		clamp_hi = (q > lim - 1'b1) ? lim - 1'b1 : q;
	endfunction

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign ts_eff = (tile_size_q == 8'd0) ? 8'd1 : tile_size_q;

	assign wr_tile = accept && (req_type == tmc_pkg::REQ_WRITE)
		&& (int'(tile_col) < tmc_pkg::MAX_COLS) && (int'(tile_row) < tmc_pkg::MAX_ROWS);

	// The clearing pass and tile writes never overlap: writes need busy low.
	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_addr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = wr_tile;
			ram_waddr = AW'(tile_row) * AW'(tmc_pkg::MAX_COLS) + AW'(tile_col);
			ram_wdata = TB'(tile_value);
		end
	end

	assign ram_raddr = tile_addr(col_q, row_q);

	tmc_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign div_ctrl.load = (state_q == ST_PREP);
	assign div_ctrl.step = (state_q == ST_DIV);

	tmc_fdiv u_div_left (
		.clk (clk), .ctrl (div_ctrl), .num (left_n_q), .den (ts_eff),
		.quo (q_left), .neg (n_left)
	);

	tmc_fdiv u_div_right (
		.clk (clk), .ctrl (div_ctrl), .num (right_n_q), .den (ts_eff),
		.quo (q_right), .neg (n_right)
	);

	tmc_fdiv u_div_top (
		.clk (clk), .ctrl (div_ctrl), .num (top_n_q), .den (ts_eff),
		.quo (q_top), .neg (n_top)
	);

	tmc_fdiv u_div_bottom (
		.clk (clk), .ctrl (div_ctrl), .num (bottom_n_q), .den (ts_eff),
		.quo (q_bottom), .neg (n_bottom)
	);

	// Clamp both spans to the map in use. A negative high end, or a map size
	// of zero, leaves nothing covered.
	always_comb begin
		lim_c = (QW'(map_cols_q) > QW'(tmc_pkg::MAX_COLS)) ?
			QW'(tmc_pkg::MAX_COLS) : QW'(map_cols_q);
		lim_r = (QW'(map_rows_q) > QW'(tmc_pkg::MAX_ROWS)) ?
			QW'(tmc_pkg::MAX_ROWS) : QW'(map_rows_q);
		lo_c  = n_left ? '0 : q_left;
		lo_r  = n_top ? '0 : q_top;
		hi_c  = clamp_hi(q_right, lim_c);
		hi_r  = clamp_hi(q_bottom, lim_r);
		empty_c = (lim_c == '0) || n_right || (lo_c > hi_c);
		empty_r = (lim_r == '0) || n_bottom || (lo_r > hi_r);
	end

	assign last_issue = (col_q == hi_col_q) && (row_q == hi_row_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_size_q <= 8'd32;
			map_cols_q  <= 7'd64;
			map_rows_q  <= 7'd64;
		end else if (cfg_we) begin
			case (cfg_index)
				tmc_pkg::CFG_TILE_SIZE: tile_size_q <= cfg_data;
				tmc_pkg::CFG_MAP_COLS:  map_cols_q  <= cfg_data[6:0];
				tmc_pkg::CFG_MAP_ROWS:  map_rows_q  <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// Request payload.
	always_ff @(posedge clk) begin
		if (accept) begin
			left_n_q   <= (QW+1)'(rect_x);
			right_n_q  <= (QW+1)'(rect_x) + $signed({2'b00, rect_w});
			top_n_q    <= (QW+1)'(rect_y);
			bottom_n_q <= (QW+1)'(rect_y) + $signed({2'b00, rect_h});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
			cnt_q      <= '0;
			col_q      <= '0;
			row_q      <= '0;
			lo_row_q   <= '0;
			hi_col_q   <= '0;
			hi_row_q   <= '0;
			issue_q    <= 1'b0;
			vld_s1     <= 1'b0;
			last_s1    <= 1'b0;
			done_q     <= 1'b0;
			hit_q      <= 1'b0;
			first_q    <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == AW'(tmc_pkg::DEPTH - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (req_type == tmc_pkg::REQ_QUERY) begin
							state_q <= ST_PREP;
						end else begin
							done_q  <= 1'b1;
							hit_q   <= 1'b0;
							first_q <= '0;
						end
					end
				end
				ST_PREP: begin
					cnt_q   <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == tmc_pkg::CNT_W'(tmc_pkg::DIV_STEPS - 1)) begin
						state_q <= ST_SPAN;
					end
				end
				ST_SPAN: begin
					if (empty_c || empty_r) begin
						done_q  <= 1'b1;
						hit_q   <= 1'b0;
						first_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						col_q    <= lo_c[CW-1:0];
						row_q    <= lo_r[RW-1:0];
						lo_row_q <= lo_r[RW-1:0];
						hi_col_q <= hi_c[CW-1:0];
						hi_row_q <= hi_r[RW-1:0];
						issue_q  <= 1'b1;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					// Reads go out one a cycle, rows inner, columns outer; the data
					// of each comes back on the next cycle.
					vld_s1  <= issue_q;
					last_s1 <= last_issue;
					if (issue_q) begin
						if (row_q == hi_row_q) begin
							row_q <= lo_row_q;
							col_q <= col_q + 1'b1;
						end else begin
							row_q <= row_q + 1'b1;
						end
						if (last_issue) begin
							issue_q <= 1'b0;
						end
					end
					if (vld_s1 && (ram_rdata != '0)) begin
						// First nonzero tile ends the scan; a read still in flight
						// is dropped.
						done_q  <= 1'b1;
						hit_q   <= 1'b1;
						first_q <= 8'(ram_rdata);
						issue_q <= 1'b0;
						vld_s1  <= 1'b0;
						state_q <= ST_IDLE;
					end else if (vld_s1 && last_s1) begin
						done_q  <= 1'b1;
						hit_q   <= 1'b0;
						first_q <= '0;
						vld_s1  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done       = done_q;
	assign hit        = hit_q;
	assign first_tile = first_q;

endmodule

`default_nettype wire

FILE: src/tmc_fdiv.sv
// ----------------------------------------------------------------------------
// tmc_fdiv
// Floor division of a 17-bit signed value by a positive 8-bit divisor,
// restoring, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tmc_fdiv (
	input  wire logic                       clk,
	input  wire tmc_pkg::div_ctrl_t         ctrl,
	input  wire logic signed [tmc_pkg::QW:0] num,
	input  wire logic [tmc_pkg::DW-1:0]     den,
	output logic [tmc_pkg::QW-1:0]          quo,
	output logic                            neg
);

	logic [tmc_pkg::QW-1:0] quo_q;
	logic [tmc_pkg::DW-1:0] rem_q;
	logic                   neg_q;
	logic [tmc_pkg::QW+1:0] mag_wide;
	logic [tmc_pkg::DW:0]   trial;
	logic                   fits;

	// For a negative value, ceil(-n / d) = (-n + d - 1) / d, and -n - 1 = ~n.
	always_comb begin
		if (num[tmc_pkg::QW]) begin
			mag_wide = (tmc_pkg::QW+2)'(~num) + (tmc_pkg::QW+2)'(den);
		end else begin
			mag_wide = (tmc_pkg::QW+2)'(num);
		end
		trial = {rem_q, quo_q[tmc_pkg::QW-1]};
		fits  = (trial >= {1'b0, den});
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			quo_q <= mag_wide[tmc_pkg::QW-1:0];
			rem_q <= '0;
			neg_q <= num[tmc_pkg::QW];
		end else if (ctrl.step) begin
			if (fits) begin
				rem_q <= tmc_pkg::DW'(trial - {1'b0, den});
				quo_q <= {quo_q[tmc_pkg::QW-2:0], 1'b1};
			end else begin
				rem_q <= trial[tmc_pkg::DW-1:0];
				quo_q <= {quo_q[tmc_pkg::QW-2:0], 1'b0};
			end
		end
	end

	assign quo = quo_q;
	assign neg = neg_q;

endmodule

`default_nettype wire

FILE: src/tmc_ram.sv
// ----------------------------------------------------------------------------
// tmc_ram
// Tile store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tmc_ram (
	input  wire logic                          clk,
	input  wire logic                          we,
	input  wire logic [tmc_pkg::ADDR_W-1:0]    waddr,
	input  wire logic [tmc_pkg::TILE_BITS-1:0] wdata,
	input  wire logic [tmc_pkg::ADDR_W-1:0]    raddr,
	output logic [tmc_pkg::TILE_BITS-1:0]      rdata
);

	logic [tmc_pkg::TILE_BITS-1:0] mem [tmc_pkg::DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

FILE: src/tmc_checker.sv
// ----------------------------------------------------------------------------
// tmc_checker
// Port-level checks of the tile map collision core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module tmc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       start,
	input wire logic       busy,
	input wire logic       req_type,
	input wire logic       done,
	input wire logic       hit,
	input wire logic [7:0] first_tile
);

	// A tile write answers on the very next cycle with no hit.
	a_write_result: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req_type == tmc_pkg::REQ_WRITE)
		|=> done && !hit && (first_tile == 8'd0))
		else $error("tile write did not answer with a clear result");

	// An accepted query raises busy and gives no result straight away.
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (req_type == tmc_pkg::REQ_QUERY) |=> busy && !done)
		else $error("query accepted without busy");

	// A hit always carries a nonzero tile code.
	a_hit_code: assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> (first_tile != 8'd0))
		else $error("hit reported with empty tile code");

	// Outside the clearing pass, busy only rises on an accepted request.
	a_busy_rise: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(busy) |-> $past(start))
		else $error("busy rose without a request");

endmodule

bind tilemap_rect_collision_core tmc_checker u_tmc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.req_type   (req_type),
	.done       (done),
	.hit        (hit),
	.first_tile (first_tile)
);

`default_nettype wire
